// ===== rtl/sgm_pkg.sv =====
// Package for the message segmenter: shared types and fixed constants.
// Used by sgm_front, sgm_fifo, sgm_back and the top level. No dependencies.
package sgm_pkg;

  // Counter width covering the largest supported payload size (255 bytes).
  localparam int CNT_W = 8;
  localparam int LEN_W = 16;
  localparam int IDX_W = 6;

  // Packet type codes carried in the header's top two bits.
  localparam logic [1:0] PKT_SINGLE = 2'b00;
  localparam logic [1:0] PKT_FIRST  = 2'b01;
  localparam logic [1:0] PKT_MIDDLE = 2'b10;
  localparam logic [1:0] PKT_LAST   = 2'b11;

  // Command queue depth and pointer width.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // One classified input byte: what the back end must emit for it.
  typedef struct packed {
    logic             hdr_en;     // emit header byte first
    logic [7:0]       hdr;        // header byte
    logic [7:0]       data;       // message byte
    logic             data_pend;  // data byte closes a packet
    logic             data_mend;  // data byte closes the message
    logic [CNT_W-1:0] pad_cnt;    // zero bytes after the data byte
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HDR,
    BK_DATA,
    BK_PAD
  } bk_state_t;

endpackage

// ===== rtl/sgm_front.sv =====
// Front end of the message segmenter: tracks message state and classifies
// each input byte into a command for the back end. Depends on sgm_pkg.
module sgm_front #(
  parameter int PAYLOAD_BYTES      = 41,
  parameter int MAX_MESSAGE_LENGTH = 65535
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic [sgm_pkg::LEN_W-1:0] in_message_length,
  input  logic                      q_full,
  output logic                      q_push,
  output sgm_pkg::cmd_t             q_cmd
);

  logic                      in_msg_r, in_msg_nxt;
  logic [sgm_pkg::LEN_W-1:0] rem_r, rem_nxt;
  logic [sgm_pkg::CNT_W-1:0] pos_r, pos_nxt;
  logic [sgm_pkg::IDX_W-1:0] pkt_r, pkt_nxt;
  logic                      first_r, first_nxt;
  logic                      single_r, single_nxt;

  logic                      accept;
  logic                      drop;
  logic [sgm_pkg::LEN_W-1:0] len_c;
  logic [sgm_pkg::LEN_W-1:0] rem_eff;
  logic [sgm_pkg::LEN_W-1:0] rem_dec;
  logic [sgm_pkg::CNT_W-1:0] pos_eff;
  logic [sgm_pkg::CNT_W-1:0] pos_inc;
  logic [sgm_pkg::IDX_W-1:0] pkt_eff;
  logic                      first_eff;
  logic                      single_eff;
  logic                      done;
  logic                      full;
  logic [1:0]                ptype;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    len_c = (in_message_length > sgm_pkg::LEN_W'(MAX_MESSAGE_LENGTH)) ?
            sgm_pkg::LEN_W'(MAX_MESSAGE_LENGTH) : in_message_length;
    drop       = !in_msg_r && (in_message_length == '0);
    rem_eff    = in_msg_r ? rem_r : len_c;
    pos_eff    = in_msg_r ? pos_r : '0;
    pkt_eff    = in_msg_r ? pkt_r : '0;
    first_eff  = in_msg_r ? first_r : 1'b1;
    single_eff = in_msg_r ? single_r : (len_c <= sgm_pkg::LEN_W'(PAYLOAD_BYTES));
    pos_inc    = pos_eff + 1'b1;
    rem_dec    = rem_eff - 1'b1;
    done       = (rem_dec == '0);
    full       = (pos_inc >= sgm_pkg::CNT_W'(PAYLOAD_BYTES));

    if (first_eff) begin
      ptype = sgm_pkg::PKT_FIRST;
    end else if (rem_eff <= sgm_pkg::LEN_W'(PAYLOAD_BYTES)) begin
      ptype = sgm_pkg::PKT_LAST;
    end else begin
      ptype = sgm_pkg::PKT_MIDDLE;
    end

    q_cmd.hdr_en    = (pos_eff == '0);
    q_cmd.hdr       = single_eff ? 8'h00 : {ptype, pkt_eff};
    q_cmd.data      = in_data_byte;
    q_cmd.data_pend = full;
    q_cmd.data_mend = done && full;
    q_cmd.pad_cnt   = (done && !full) ? (sgm_pkg::CNT_W'(PAYLOAD_BYTES) - pos_inc) : '0;
    q_push          = accept && !drop;
  end

  // Next message state.
  always_comb begin
    in_msg_nxt = in_msg_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    pkt_nxt    = pkt_r;
    first_nxt  = first_r;
    single_nxt = single_r;
    if (accept && !drop) begin
      if (done) begin
        in_msg_nxt = 1'b0;
        rem_nxt    = '0;
        pos_nxt    = '0;
        pkt_nxt    = '0;
        first_nxt  = 1'b1;
        single_nxt = 1'b0;
      end else begin
        in_msg_nxt = 1'b1;
        rem_nxt    = rem_dec;
        single_nxt = single_eff;
        if (full) begin
          pos_nxt   = '0;
          pkt_nxt   = pkt_eff + 1'b1;
          first_nxt = 1'b0;
        end else begin
          pos_nxt   = pos_inc;
          pkt_nxt   = pkt_eff;
          first_nxt = first_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      rem_r    <= '0;
      pos_r    <= '0;
      pkt_r    <= '0;
      first_r  <= 1'b1;
      single_r <= 1'b0;
    end else begin
      in_msg_r <= in_msg_nxt;
      rem_r    <= rem_nxt;
      pos_r    <= pos_nxt;
      pkt_r    <= pkt_nxt;
      first_r  <= first_nxt;
      single_r <= single_nxt;
    end
  end

endmodule

// ===== rtl/sgm_fifo.sv =====
// Two-entry command queue between the segmenter's front and back ends.
// Depends on sgm_pkg for the command type.
module sgm_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sgm_pkg::cmd_t push_cmd,
  input  logic          pop,
  output sgm_pkg::cmd_t pop_cmd,
  output logic          full,
  output logic          not_empty
);

  sgm_pkg::cmd_t                entry_r [sgm_pkg::QDEPTH];
  logic [sgm_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [sgm_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [sgm_pkg::QPTR_W:0]     count_r, count_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign full      = (count_r == (sgm_pkg::QPTR_W+1)'(sgm_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (sgm_pkg::QPTR_W+1)'(do_push) - (sgm_pkg::QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/sgm_back.sv =====
// Back end of the message segmenter: plays out header, data and padding
// bytes of each queued command, one beat per cycle while out_ready is high. Depends on sgm_pkg.
module sgm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  sgm_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_packet_end,
  output logic          out_message_end,
  output logic          out_run_last
);

  sgm_pkg::bk_state_t        state_r, state_nxt;
  sgm_pkg::cmd_t             cmd_r;
  logic [sgm_pkg::CNT_W-1:0] pad_left_r, pad_left_nxt;
  logic                      beat;
  logic                      last_beat;

  assign beat      = out_valid && out_ready;
  assign last_beat = beat &&
                     (((state_r == sgm_pkg::BK_DATA) && (cmd_r.pad_cnt == '0)) ||
                      ((state_r == sgm_pkg::BK_PAD) && (pad_left_r == sgm_pkg::CNT_W'(1))));
  assign q_pop     = ((state_r == sgm_pkg::BK_IDLE) || last_beat) && q_not_empty;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    if (q_pop) begin
      state_nxt = q_cmd.hdr_en ? sgm_pkg::BK_HDR : sgm_pkg::BK_DATA;
    end else begin
      case (state_r)
        sgm_pkg::BK_IDLE: state_nxt = sgm_pkg::BK_IDLE;
        sgm_pkg::BK_HDR: begin
          if (beat) state_nxt = sgm_pkg::BK_DATA;
        end
        sgm_pkg::BK_DATA: begin
          if (beat) state_nxt = (cmd_r.pad_cnt == '0) ? sgm_pkg::BK_IDLE : sgm_pkg::BK_PAD;
        end
        sgm_pkg::BK_PAD: begin
          if (last_beat) state_nxt = sgm_pkg::BK_IDLE;
        end
        default: state_nxt = sgm_pkg::BK_IDLE;
      endcase
    end
  end

  always_comb begin
    pad_left_nxt = pad_left_r;
    if (beat && (state_r == sgm_pkg::BK_DATA)) begin
      pad_left_nxt = cmd_r.pad_cnt;
    end else if (beat && (state_r == sgm_pkg::BK_PAD)) begin
      pad_left_nxt = pad_left_r - 1'b1;
    end
  end

  // Outputs.
  always_comb begin
    out_valid       = 1'b0;
    out_byte        = 8'h00;
    out_packet_end  = 1'b0;
    out_message_end = 1'b0;
    out_run_last    = 1'b0;
    case (state_r)
      sgm_pkg::BK_IDLE: out_valid = 1'b0;
      sgm_pkg::BK_HDR: begin
        out_valid = 1'b1;
        out_byte  = cmd_r.hdr;
      end
      sgm_pkg::BK_DATA: begin
        out_valid       = 1'b1;
        out_byte        = cmd_r.data;
        out_packet_end  = cmd_r.data_pend;
        out_message_end = cmd_r.data_mend;
        out_run_last    = (cmd_r.pad_cnt == '0);
      end
      sgm_pkg::BK_PAD: begin
        out_valid       = 1'b1;
        out_packet_end  = (pad_left_r == sgm_pkg::CNT_W'(1));
        out_message_end = (pad_left_r == sgm_pkg::CNT_W'(1));
        out_run_last    = (pad_left_r == sgm_pkg::CNT_W'(1));
      end
      default: out_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    pad_left_r <= pad_left_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgm_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/message_segmenter_42_byte_packets_core.sv =====
// Message segmenter: cuts a byte stream into fixed packets of one header
// byte plus PAYLOAD_BYTES payload bytes. Depends on sgm_pkg, sgm_front,
// sgm_fifo and sgm_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one message byte per beat; the
//   message length rides on in_message_length with the first byte and is
//   ignored until the message ends. A zero length on a first byte drops it.
//   Output channel (out_valid/out_ready): one packet byte per beat with
//   packet_end, message_end and run_last flags. run_last marks the last
//   output beat caused by one input byte.
// Path: an accepted byte is registered into the command queue, then the
//   back end loads the command and presents its first output beat.
// Throughput: the output port sets the pace at one beat per cycle while
//   out_ready is high. An input byte yields one beat, two when it opens a
//   packet, and up to PAYLOAD_BYTES+1 when it closes a short last packet
//   (padding).
// Stall: when out_ready is low the back end holds its beat; the two-entry
//   command queue fills and then in_ready drops until space frees.
// Reset: synchronous, active low; clears the message state, the queue and
//   the output state, so the block comes up idle with out_valid low.
module message_segmenter_42_byte_packets_core #(
  parameter int PAYLOAD_BYTES      = 41,
  parameter int MAX_MESSAGE_LENGTH = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_message_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_packet_end,
  output logic        out_message_end,
  output logic        out_run_last
);

  // Commands travel from the classifier to the byte sequencer here.
  sgm_pkg::cmd_t push_cmd;
  sgm_pkg::cmd_t pop_cmd;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_not_empty;

  // Classify each input byte and advance the message state.
  sgm_front #(
    .PAYLOAD_BYTES      (PAYLOAD_BYTES),
    .MAX_MESSAGE_LENGTH (MAX_MESSAGE_LENGTH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_message_length (in_message_length),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_cmd             (push_cmd)
  );

  // Decouple the two sides so each can stall on its own.
  sgm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Emit header, data and padding beats.
  sgm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_cmd           (pop_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_packet_end  (out_packet_end),
    .out_message_end (out_message_end),
    .out_run_last    (out_run_last)
  );

endmodule

// ===== rtl/sgm_checker.sv =====
// Port-level checker for the message segmenter, bound to the top level.
// Depends only on the top level's ports.
module sgm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_packet_end,
  input logic       out_message_end,
  input logic       out_run_last
);

  // Hold a stalled beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(out_packet_end) && $stable(out_message_end) && $stable(out_run_last))
    else $error("stalled output beat changed");

  // A message only ends on a packet boundary.
  a_mend_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_end |-> out_packet_end)
    else $error("message_end without packet_end");

  // The message's final beat is always the last beat of its input byte.
  a_mend_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_end |-> out_run_last)
    else $error("message_end without run_last");

  // Come out of reset idle.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind message_segmenter_42_byte_packets_core sgm_checker u_sgm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_packet_end  (out_packet_end),
  .out_message_end (out_message_end),
  .out_run_last    (out_run_last)
);

// ===== tb/message_segmenter_42_byte_packets_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for message_segmenter_42_byte_packets_core: drives messages byte by byte and
// checks every packet beat against a cycle-free model of the segmenter.
// Depends on sgm_pkg and the core RTL only.
module message_segmenter_42_byte_packets_core_tb;

  localparam int PKT_PAYLOAD   = 41;
  localparam int RAND_BYTES    = 50;
  localparam int TAIL_BYTES    = 20;
  localparam int HOLD_CYCLES   = 80;    // long output hold-off to back up the input
  localparam int STUCK_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES  = 8;
  localparam int REPORT_MAX    = 10;

  // One packet beat as seen on the output channel.
  typedef struct packed {
    logic [7:0] octet;
    logic       pkt_end;
    logic       msg_end;
    logic       run_last;
  } pkt_beat_t;

  // One row of the directed table. Where typed is set, n_beats is checked against
  // the model and first_octet, read straight off the packet format, overrides it.
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] len;
    logic        typed;
    logic [7:0]  first_octet;
    logic [7:0]  n_beats;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic [15:0] in_message_length = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_packet_end;
  logic        out_message_end;
  logic        out_run_last;

  // Segmenter model state.
  bit          seg_busy;
  logic [15:0] left_cnt;
  int          pay_pos;
  logic [5:0]  pkt_idx;
  bit          first_pkt;
  bit          single_pkt;

  pkt_beat_t   pending_beats[$];

  int          mismatches;
  int          stuck_cycles;
  int          bytes_in;
  int          beats_out;
  int          msgs_sent;
  bit          traffic_gaps = 1'b1;
  bit          hold_req;

  message_segmenter_42_byte_packets_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_message_length (in_message_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_packet_end    (out_packet_end),
    .out_message_end   (out_message_end),
    .out_run_last      (out_run_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Directed rows: single-byte message, zero-length drops, a two-byte message
  // with a length riding on its second byte, a three-byte message with a zero
  // length mid-message, then a short message with the length's top bits set
  // on ignored beats.
  dir_row_t dir_rows [0:11] = '{
    '{8'hFF, 16'd1,     1'b1, 8'h00, 8'd42},
    '{8'h5A, 16'd0,     1'b1, 8'h00, 8'd0},
    '{8'h00, 16'd0,     1'b1, 8'h00, 8'd0},
    '{8'h01, 16'd2,     1'b1, 8'h00, 8'd2},
    '{8'h80, 16'hFFFF,  1'b1, 8'h80, 8'd40},
    '{8'hAA, 16'd3,     1'b1, 8'h00, 8'd2},
    '{8'h55, 16'd0,     1'b1, 8'h55, 8'd1},
    '{8'h00, 16'd0,     1'b1, 8'h00, 8'd39},
    '{8'h3C, 16'd4,     1'b0, 8'h00, 8'd0},
    '{8'hC3, 16'h1234,  1'b0, 8'h00, 8'd0},
    '{8'hF0, 16'h8000,  1'b0, 8'h00, 8'd0},
    '{8'h0F, 16'h7FFF,  1'b0, 8'h00, 8'd0}
  };

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("[%0t] mismatch: %s", $time, what);
  endfunction

  function automatic void clear_segment();
    seg_busy   = 1'b0;
    left_cnt   = '0;
    pay_pos    = 0;
    pkt_idx    = '0;
    first_pkt  = 1'b1;
    single_pkt = 1'b0;
  endfunction

  // Advance the model by one accepted byte, append the beats it causes to
  // pending_beats and return how many there are.
  function automatic int segment_byte(logic [7:0] data, logic [15:0] len);
    pkt_beat_t  run[$];
    logic [1:0] kind;
    logic [7:0] hdr;
    if (!seg_busy) begin
      if (len == 16'd0)
        return 0;               // drop: zero length on an idle block
      seg_busy   = 1'b1;
      left_cnt   = len;
      pay_pos    = 0;
      pkt_idx    = '0;
      first_pkt  = 1'b1;
      single_pkt = (len <= PKT_PAYLOAD);
    end
    if (pay_pos == 0) begin
      if (single_pkt) begin
        hdr = {sgm_pkg::PKT_SINGLE, 6'd0};
      end else begin
        if (first_pkt)
          kind = sgm_pkg::PKT_FIRST;
        else if (left_cnt <= PKT_PAYLOAD)
          kind = sgm_pkg::PKT_LAST;
        else
          kind = sgm_pkg::PKT_MIDDLE;
        hdr = {kind, pkt_idx};
      end
      run.push_back('{hdr, 1'b0, 1'b0, 1'b0});
    end
    pay_pos++;
    left_cnt--;
    if (left_cnt == 16'd0) begin
      if (pay_pos >= PKT_PAYLOAD) begin
        run.push_back('{data, 1'b1, 1'b1, 1'b0});
      end else begin
        run.push_back('{data, 1'b0, 1'b0, 1'b0});
        // zero pad the last packet up to a full payload
        while (pay_pos < PKT_PAYLOAD) begin
          pay_pos++;
          run.push_back('{8'h00, pay_pos == PKT_PAYLOAD, pay_pos == PKT_PAYLOAD, 1'b0});
        end
      end
      clear_segment();
    end else if (pay_pos >= PKT_PAYLOAD) begin
      run.push_back('{data, 1'b1, 1'b0, 1'b0});
      pay_pos   = 0;
      pkt_idx   = pkt_idx + 6'd1;   // index wraps modulo 64
      first_pkt = 1'b0;
    end else begin
      run.push_back('{data, 1'b0, 1'b0, 1'b0});
    end
    run[run.size()-1].run_last = 1'b1;
    foreach (run[i])
      pending_beats.push_back(run[i]);
    return run.size();
  endfunction

  // Offer one byte, optionally after a short gap, and hold it until accepted.
  task automatic send_octet(input logic [7:0] data, input logic [15:0] len,
                            output int produced);
    if (traffic_gaps && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_message_length <= len;
    do @(posedge clk); while (!in_ready);
    produced = segment_byte(data, len);
    bytes_in++;
  endtask

  // Send a whole message; lengths on the later beats are random and ignored.
  task automatic send_message(input int len);
    int produced;
    for (int i = 0; i < len; i++)
      send_octet(8'($urandom_range(0, 255)),
                 (i == 0) ? len[15:0] : 16'($urandom_range(0, 65535)),
                 produced);
    msgs_sent++;
  endtask

  // Mostly short or single-packet messages, some multi-packet ones, exact
  // payload multiples and their neighbors.
  function automatic int pick_length();
    case ($urandom_range(0, 8))
      0, 1, 2: return $urandom_range(1, PKT_PAYLOAD);
      3, 4:    return $urandom_range(PKT_PAYLOAD + 1, 130);
      5:       return PKT_PAYLOAD * $urandom_range(1, 3);
      6:       return PKT_PAYLOAD * $urandom_range(1, 2) + $urandom_range(0, 2) - 1;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // Receiver: random hold bursts, plus one long hold-off on request so the
  // command queue fills and in_ready drops.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (traffic_gaps && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each output beat with the oldest pending one.
  always @(posedge clk) begin
    pkt_beat_t got;
    pkt_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_byte, out_packet_end, out_message_end, out_run_last};
      beats_out++;
      if (pending_beats.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat byte=%02h pend=%0b mend=%0b last=%0b",
                                got.octet, got.pkt_end, got.msg_end, got.run_last));
      end else begin
        want = pending_beats.pop_front();
        if (got !== want)
          flag_mismatch($sformatf(
            "beat %0d exp byte=%02h pend=%0b mend=%0b last=%0b, got byte=%02h pend=%0b mend=%0b last=%0b",
            beats_out, want.octet, want.pkt_end, want.msg_end, want.run_last,
            got.octet, got.pkt_end, got.msg_end, got.run_last));
      end
    end
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", STUCK_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int  produced;
    int  len;
    int  base;
    int  rand_start;
    bit  hold_done;
    clear_segment();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table. Typed rows pin the first beat and the beat count.
    foreach (dir_rows[r]) begin
      send_octet(dir_rows[r].data, dir_rows[r].len, produced);
      base = pending_beats.size() - produced;
      if (dir_rows[r].typed) begin
        if (produced != dir_rows[r].n_beats)
          flag_mismatch($sformatf("row %0d: %0d beats expected, model gives %0d",
                                  r, dir_rows[r].n_beats, produced));
        else if (produced > 0)
          pending_beats[base].octet = dir_rows[r].first_octet;
      end
    end
    msgs_sent += 4;
    // check that the last rows closed the four-byte message they opened
    if (seg_busy)
      flag_mismatch("directed table left a message open");

    // Random messages with zero-length noise between them; once, hold the
    // output off during a two-packet message.
    rand_start = bytes_in;
    hold_done  = 1'b0;
    while (bytes_in - rand_start < RAND_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        send_octet(8'($urandom_range(0, 255)), 16'd0, produced);
        bytes_in--;                       // dropped bytes do not count
      end else begin
        len = pick_length();
        if (!hold_done && bytes_in - rand_start >= 8) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
          len       = PKT_PAYLOAD + 1;
        end
        send_message(len);
      end
    end

    // Final stretch at full rate on both sides.
    traffic_gaps = 1'b0;
    rand_start = bytes_in;
    while (bytes_in - rand_start < TAIL_BYTES)
      send_message(pick_length());

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d messages, %0d bytes in and %0d packet beats out,",
             msgs_sent, bytes_in, beats_out);
    $display("with zero-length drops, padded short packets and a %0d-cycle hold-off; %0d mismatches.",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sgm_pkg.sv
rtl/sgm_front.sv
rtl/sgm_fifo.sv
rtl/sgm_back.sv
rtl/message_segmenter_42_byte_packets_core.sv
rtl/sgm_checker.sv
tb/message_segmenter_42_byte_packets_core_tb.sv
